// ===== sv/bpc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometric compensation block: the
// calibration word set, register map codes, datapath widths and limits.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int RAW_W   = 24;
    localparam int COEFF_W = 16;
    localparam int TEMP_W  = 15;
    localparam int PRES_W  = 17;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Number of register stages from input transfer to the output register.
    localparam int NSTG = 10;

    // Datapath widths.
    localparam int DT_W    = 26;   // raw temperature minus scaled reference
    localparam int CS_W    = 17;   // calibration word as a positive signed value
    localparam int PROD_W  = DT_W + CS_W;
    localparam int DD_W    = 2 * DT_W;
    localparam int T1_W    = 20;   // first-order temperature
    localparam int T2_W    = 17;   // second-order temperature term
    localparam int TF_W    = 21;   // corrected temperature before clamping
    localparam int SQ_W    = 2 * TF_W;
    localparam int OS_W    = 40;   // OFF and SENS terms
    localparam int SPLIT_W = 20;   // low part of SENS for the split multiply
    localparam int PPLO_W  = RAW_W + SPLIT_W;
    localparam int PPHI_W  = RAW_W + 1 + (OS_W - SPLIT_W);
    localparam int FULL_W  = 64;
    localparam int Q_W     = FULL_W - 21;
    localparam int R_W     = Q_W + 1;
    localparam int PR_W    = R_W - 15;

    localparam logic signed [T1_W-1:0] TEMP_REF  = 20'sd2000;
    localparam logic signed [T1_W-1:0] TEMP_COLD = -20'sd1500;
    localparam logic signed [TF_W-1:0] TEMP_MIN  = -21'sd4000;
    localparam logic signed [TF_W-1:0] TEMP_MAX  = 21'sd8500;
    localparam logic signed [PR_W-1:0] PRES_MIN  = 29'sd1000;
    localparam logic signed [PR_W-1:0] PRES_MAX  = 29'sd120000;

    typedef enum logic [2:0] {
        REG_SENS        = 3'd0,
        REG_OFFSET      = 3'd1,
        REG_SENS_TEMP   = 3'd2,
        REG_OFFSET_TEMP = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SENS   = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [COEFF_W-1:0] sens_coeff;
        logic [COEFF_W-1:0] offset_coeff;
        logic [COEFF_W-1:0] sens_temp_coeff;
        logic [COEFF_W-1:0] offset_temp_coeff;
        logic [COEFF_W-1:0] ref_temperature;
        logic [COEFF_W-1:0] temp_sens_coeff;
    } cfg_t;

endpackage

// ===== sv/bpc_in_if.sv =====
// ----------------------------------------------------------------------------
// bpc_in_if
// Input channel: one raw pressure and temperature conversion pair per transfer.
// ----------------------------------------------------------------------------
interface bpc_in_if;

    logic                      valid;
    logic                      ready;
    logic [bpc_pkg::RAW_W-1:0] raw_pressure;
    logic [bpc_pkg::RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature,
                    input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature,
                  output ready);

endinterface

// ===== sv/bpc_out_if.sv =====
// ----------------------------------------------------------------------------
// bpc_out_if
// Output channel: one compensated temperature and pressure per transfer.
// ----------------------------------------------------------------------------
interface bpc_out_if;

    logic                              valid;
    logic                              ready;
    logic signed [bpc_pkg::TEMP_W-1:0] temperature_centi;
    logic        [bpc_pkg::PRES_W-1:0] pressure_centi;

    modport source (output valid, output temperature_centi, output pressure_centi,
                    input ready);
    modport sink (input valid, input temperature_centi, input pressure_centi,
                  output ready);

endinterface

// ===== sv/baro_pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// Second-order barometric compensation of raw pressure and temperature
// readings with six calibration words written over an APB-style port.
// ----------------------------------------------------------------------------
// Usage:
//   The six calibration words sit at byte addresses 0, 4, ..., 20 and are
//   written while no reading is in flight; they read back over prdata.
//   Each transfer on the sample channel carries one raw pressure and one raw
//   temperature conversion. Each produces exactly one transfer on the result
//   channel with temperature in 0.01 C and pressure in 0.01 mbar, both
//   clamped to their ranges.
//   The datapath is a ten-stage pipeline that takes a new sample every cycle
//   unless every stage is full while the receiver holds ready low. The stage
//   count is set by the multiplier chain dT products, squares, and the
//   D1 times SENS product split into two partial products.
//   When the receiver holds ready low, the result stays in the output
//   register, empty stages in front of it keep filling, and sample ready
//   drops only once every stage holds an item.
//   Reset clears all stage valid bits and sets every calibration word to zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [bpc_pkg::DATA_W-1:0]   pwdata,
    output logic [bpc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    bpc_in_if.sink                       sample,
    bpc_out_if.source                    result
);

    bpc_pkg::cfg_t     cfg_reg;
    bpc_pkg::reg_idx_t reg_sel;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_sel = bpc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                bpc_pkg::REG_SENS:        cfg_reg.sens_coeff        <= pwdata[15:0];
                bpc_pkg::REG_OFFSET:      cfg_reg.offset_coeff      <= pwdata[15:0];
                bpc_pkg::REG_SENS_TEMP:   cfg_reg.sens_temp_coeff   <= pwdata[15:0];
                bpc_pkg::REG_OFFSET_TEMP: cfg_reg.offset_temp_coeff <= pwdata[15:0];
                bpc_pkg::REG_REF_TEMP:    cfg_reg.ref_temperature   <= pwdata[15:0];
                bpc_pkg::REG_TEMP_SENS:   cfg_reg.temp_sens_coeff   <= pwdata[15:0];
                default:                  cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            bpc_pkg::REG_SENS:        prdata = {16'h0000, cfg_reg.sens_coeff};
            bpc_pkg::REG_OFFSET:      prdata = {16'h0000, cfg_reg.offset_coeff};
            bpc_pkg::REG_SENS_TEMP:   prdata = {16'h0000, cfg_reg.sens_temp_coeff};
            bpc_pkg::REG_OFFSET_TEMP: prdata = {16'h0000, cfg_reg.offset_temp_coeff};
            bpc_pkg::REG_REF_TEMP:    prdata = {16'h0000, cfg_reg.ref_temperature};
            bpc_pkg::REG_TEMP_SENS:   prdata = {16'h0000, cfg_reg.temp_sens_coeff};
            default:                  prdata = '0;
        endcase
    end

    bpc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .sample (sample),
        .result (result)
    );

`ifndef SYNTHESIS
    // With the output register free, the whole pipeline can move.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!result.valid || result.ready) |-> sample.ready)
        else $error("sample channel blocked while the output can drain");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.temperature_centi >= -15'sd4000)
                      && (result.temperature_centi <= 15'sd8500))
        else $error("temperature result outside its clamp range");

    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.pressure_centi >= 17'd1000)
                      && (result.pressure_centi <= 17'd120000))
        else $error("pressure result outside its clamp range");
`endif

endmodule

// ===== sv/bpc_core.sv =====
// ----------------------------------------------------------------------------
// bpc_core
// Ten-stage compensation pipeline with per-stage valid bits and a ready
// chain that lets bubbles close up while the output is stalled.
// ----------------------------------------------------------------------------
module bpc_core (
    input  logic            clk,
    input  logic            rst_n,
    input  bpc_pkg::cfg_t   cfg,
    bpc_in_if.sink          sample,
    bpc_out_if.source       result
);

    localparam int N = bpc_pkg::NSTG;

    logic [N-1:0] vld_reg;
    logic [N-1:0] vld_next;
    logic [N-1:0] stg_en;

    // A stage may load when it is empty or when its contents move on.
    always_comb
    begin
        stg_en[N-1] = !vld_reg[N-1] || result.ready;
        for (int k = N - 2; k >= 0; k--)
        begin
            stg_en[k] = !vld_reg[k] || stg_en[k+1];
        end
        vld_next[0] = stg_en[0] ? sample.valid : vld_reg[0];
        for (int k = 1; k < N; k++)
        begin
            vld_next[k] = stg_en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign sample.ready = stg_en[0];

    // Calibration words as positive signed operands.
    logic signed [bpc_pkg::CS_W-1:0] c3_s, c4_s, c6_s;
    assign c3_s = $signed({1'b0, cfg.sens_temp_coeff});
    assign c4_s = $signed({1'b0, cfg.offset_temp_coeff});
    assign c6_s = $signed({1'b0, cfg.temp_sens_coeff});

    // Stage 1: temperature difference.
    logic signed [bpc_pkg::DT_W-1:0]  dt_reg, dt_next;
    logic        [bpc_pkg::RAW_W-1:0] d1_s1_reg;

    assign dt_next = $signed({2'b00, sample.raw_temperature})
                   - $signed({2'b00, cfg.ref_temperature, 8'h00});

    always_ff @(posedge clk)
    begin
        if (stg_en[0])
        begin
            dt_reg    <= dt_next;
            d1_s1_reg <= sample.raw_pressure;
        end
    end

    // Stage 2: the four products of dT.
    logic signed [bpc_pkg::PROD_W-1:0] pt_reg, po_reg, ps_reg;
    logic signed [bpc_pkg::PROD_W-1:0] pt_next, po_next, ps_next;
    logic signed [bpc_pkg::DD_W-1:0]   dd_reg, dd_next;
    logic        [bpc_pkg::RAW_W-1:0]  d1_s2_reg;

    always_comb
    begin
        pt_next = dt_reg * c6_s;
        po_next = dt_reg * c4_s;
        ps_next = dt_reg * c3_s;
        dd_next = dt_reg * dt_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[1])
        begin
            pt_reg    <= pt_next;
            po_reg    <= po_next;
            ps_reg    <= ps_next;
            dd_reg    <= dd_next;
            d1_s2_reg <= d1_s1_reg;
        end
    end

    // Stage 3: first-order temperature, OFF and SENS.
    logic signed [bpc_pkg::T1_W-1:0]  temp1_reg, temp1_next;
    logic signed [bpc_pkg::OS_W-1:0]  off1_reg, off1_next, sens1_reg, sens1_next;
    logic        [bpc_pkg::T2_W-1:0]  t2_reg, t2_next;
    logic        [bpc_pkg::RAW_W-1:0] d1_s3_reg;
    logic signed [bpc_pkg::PROD_W-1:0] pt_sh, po_sh, ps_sh;

    always_comb
    begin
        pt_sh      = pt_reg >>> 23;
        po_sh      = po_reg >>> 7;
        ps_sh      = ps_reg >>> 8;
        temp1_next = pt_sh[bpc_pkg::T1_W-1:0] + bpc_pkg::TEMP_REF;
        off1_next  = $signed({8'h00, cfg.offset_coeff, 16'h0000})
                   + po_sh[bpc_pkg::OS_W-1:0];
        sens1_next = $signed({9'h000, cfg.sens_coeff, 15'h0000})
                   + ps_sh[bpc_pkg::OS_W-1:0];
        // dT squared is never negative and stays below 2^48.
        t2_next    = dd_reg[47:31];
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[2])
        begin
            temp1_reg <= temp1_next;
            off1_reg  <= off1_next;
            sens1_reg <= sens1_next;
            t2_reg    <= t2_next;
            d1_s3_reg <= d1_s2_reg;
        end
    end

    // Stage 4: range tests and the two squared temperature distances.
    logic                             lt_ref_reg, lt_cold_reg;
    logic signed [bpc_pkg::SQ_W-1:0]  sqa_reg, sqa_next, sqb_reg, sqb_next;
    logic signed [bpc_pkg::TF_W-1:0]  da, db;
    logic signed [bpc_pkg::T1_W-1:0]  temp1_s4_reg;
    logic signed [bpc_pkg::OS_W-1:0]  off1_s4_reg, sens1_s4_reg;
    logic        [bpc_pkg::T2_W-1:0]  t2_s4_reg;
    logic        [bpc_pkg::RAW_W-1:0] d1_s4_reg;

    always_comb
    begin
        da       = $signed({temp1_reg[bpc_pkg::T1_W-1], temp1_reg}) - 21'sd2000;
        db       = $signed({temp1_reg[bpc_pkg::T1_W-1], temp1_reg}) + 21'sd1500;
        sqa_next = da * da;
        sqb_next = db * db;
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[3])
        begin
            lt_ref_reg   <= temp1_reg < bpc_pkg::TEMP_REF;
            lt_cold_reg  <= temp1_reg < bpc_pkg::TEMP_COLD;
            sqa_reg      <= sqa_next;
            sqb_reg      <= sqb_next;
            temp1_s4_reg <= temp1_reg;
            off1_s4_reg  <= off1_reg;
            sens1_s4_reg <= sens1_reg;
            t2_s4_reg    <= t2_reg;
            d1_s4_reg    <= d1_s3_reg;
        end
    end

    // Stage 5: second-order OFF2, SENS2 and corrected temperature.
    logic signed [bpc_pkg::OS_W-1:0]  off2_reg, off2_next, sens2_reg, sens2_next;
    logic signed [bpc_pkg::OS_W-1:0]  sqa_w, sqb_w, five_a, seven_b, eleven_b;
    logic signed [bpc_pkg::TF_W-1:0]  tempf_reg, tempf_next;
    logic signed [bpc_pkg::OS_W-1:0]  off1_s5_reg, sens1_s5_reg;
    logic        [bpc_pkg::RAW_W-1:0] d1_s5_reg;

    always_comb
    begin
        // Both squares are below 2^36, so the narrowing keeps their value.
        sqa_w    = sqa_reg[bpc_pkg::OS_W-1:0];
        sqb_w    = sqb_reg[bpc_pkg::OS_W-1:0];
        five_a   = (sqa_w <<< 2) + sqa_w;
        seven_b  = (sqb_w <<< 3) - sqb_w;
        eleven_b = (sqb_w <<< 3) + (sqb_w <<< 1) + sqb_w;
        off2_next  = '0;
        sens2_next = '0;
        tempf_next = $signed({temp1_s4_reg[bpc_pkg::T1_W-1], temp1_s4_reg});
        if (lt_ref_reg)
        begin
            off2_next  = five_a >>> 1;
            sens2_next = five_a >>> 2;
            tempf_next = tempf_next - $signed({4'h0, t2_s4_reg});
            if (lt_cold_reg)
            begin
                off2_next  = off2_next + seven_b;
                sens2_next = sens2_next + (eleven_b >>> 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[4])
        begin
            off2_reg     <= off2_next;
            sens2_reg    <= sens2_next;
            tempf_reg    <= tempf_next;
            off1_s5_reg  <= off1_s4_reg;
            sens1_s5_reg <= sens1_s4_reg;
            d1_s5_reg    <= d1_s4_reg;
        end
    end

    // Stage 6: final OFF and SENS, temperature clamp.
    logic signed [bpc_pkg::OS_W-1:0]   offf_reg, offf_next, sensf_reg, sensf_next;
    logic signed [bpc_pkg::TEMP_W-1:0] tempc_reg, tempc_next;
    logic        [bpc_pkg::RAW_W-1:0]  d1_s6_reg;

    always_comb
    begin
        offf_next  = off1_s5_reg - off2_reg;
        sensf_next = sens1_s5_reg - sens2_reg;
        if (tempf_reg < bpc_pkg::TEMP_MIN)
        begin
            tempc_next = bpc_pkg::TEMP_MIN[bpc_pkg::TEMP_W-1:0];
        end
        else if (tempf_reg > bpc_pkg::TEMP_MAX)
        begin
            tempc_next = bpc_pkg::TEMP_MAX[bpc_pkg::TEMP_W-1:0];
        end
        else
        begin
            tempc_next = tempf_reg[bpc_pkg::TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[5])
        begin
            offf_reg  <= offf_next;
            sensf_reg <= sensf_next;
            tempc_reg <= tempc_next;
            d1_s6_reg <= d1_s5_reg;
        end
    end

    // Stage 7: D1 times SENS as two partial products.
    logic        [bpc_pkg::PPLO_W-1:0] pplo_reg, pplo_next;
    logic signed [bpc_pkg::PPHI_W-1:0] pphi_reg, pphi_next;
    logic signed [bpc_pkg::OS_W-1:0]   offf_s7_reg;
    logic signed [bpc_pkg::TEMP_W-1:0] tempc_s7_reg;

    always_comb
    begin
        pplo_next = d1_s6_reg * sensf_reg[bpc_pkg::SPLIT_W-1:0];
        pphi_next = $signed({1'b0, d1_s6_reg})
                  * $signed(sensf_reg[bpc_pkg::OS_W-1:bpc_pkg::SPLIT_W]);
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[6])
        begin
            pplo_reg     <= pplo_next;
            pphi_reg     <= pphi_next;
            offf_s7_reg  <= offf_reg;
            tempc_s7_reg <= tempc_reg;
        end
    end

    // Stage 8: combine the partial products and shift down by 21.
    logic signed [bpc_pkg::FULL_W-1:0] full_prod;
    logic signed [bpc_pkg::Q_W-1:0]    q_reg;
    logic signed [bpc_pkg::OS_W-1:0]   offf_s8_reg;
    logic signed [bpc_pkg::TEMP_W-1:0] tempc_s8_reg;

    always_comb
    begin
        full_prod = ($signed({{(bpc_pkg::FULL_W - bpc_pkg::PPHI_W){pphi_reg[bpc_pkg::PPHI_W-1]}},
                              pphi_reg}) <<< bpc_pkg::SPLIT_W)
                  + $signed({{(bpc_pkg::FULL_W - bpc_pkg::PPLO_W){1'b0}}, pplo_reg});
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[7])
        begin
            q_reg        <= full_prod[bpc_pkg::FULL_W-1:21];
            offf_s8_reg  <= offf_s7_reg;
            tempc_s8_reg <= tempc_s7_reg;
        end
    end

    // Stage 9: subtract OFF and shift down by 15.
    logic signed [bpc_pkg::R_W-1:0]    r_full;
    logic signed [bpc_pkg::PR_W-1:0]   pr_reg;
    logic signed [bpc_pkg::TEMP_W-1:0] tempc_s9_reg;

    assign r_full = $signed({q_reg[bpc_pkg::Q_W-1], q_reg})
                  - $signed({{(bpc_pkg::R_W - bpc_pkg::OS_W){offf_s8_reg[bpc_pkg::OS_W-1]}},
                             offf_s8_reg});

    always_ff @(posedge clk)
    begin
        if (stg_en[8])
        begin
            pr_reg       <= r_full[bpc_pkg::R_W-1:15];
            tempc_s9_reg <= tempc_s8_reg;
        end
    end

    // Stage 10: pressure clamp into the output register.
    logic signed [bpc_pkg::TEMP_W-1:0] temperature_centi_reg;
    logic        [bpc_pkg::PRES_W-1:0] pressure_centi_reg, pressure_centi_next;

    always_comb
    begin
        if (pr_reg < bpc_pkg::PRES_MIN)
        begin
            pressure_centi_next = bpc_pkg::PRES_MIN[bpc_pkg::PRES_W-1:0];
        end
        else if (pr_reg > bpc_pkg::PRES_MAX)
        begin
            pressure_centi_next = bpc_pkg::PRES_MAX[bpc_pkg::PRES_W-1:0];
        end
        else
        begin
            pressure_centi_next = pr_reg[bpc_pkg::PRES_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_en[9])
        begin
            temperature_centi_reg <= tempc_s9_reg;
            pressure_centi_reg    <= pressure_centi_next;
        end
    end

    assign result.valid             = vld_reg[N-1];
    assign result.temperature_centi = temperature_centi_reg;
    assign result.pressure_centi    = pressure_centi_reg;

endmodule

// ===== dv/bpc_comp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bpc_comp_checker
// Watches the register port and both channels of the barometric compensation
// block. It keeps its own copy of the calibration words, works out the
// compensated temperature and pressure for every sample transfer, and compares
// each result transfer with the oldest outstanding reading. Register reads are
// checked against the copy as well.
// ----------------------------------------------------------------------------
module bpc_comp_checker
    import bpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic [DATA_W-1:0] prdata,
    input  logic              pready,
    bpc_in_if                 sample,
    bpc_out_if                result,
    output int                mismatches,
    output int                pending
);

    localparam longint T_REF     = 64'sd2000;
    localparam longint T_COLD    = -64'sd1500;
    localparam longint T_LOW     = -64'sd4000;
    localparam longint T_HIGH    = 64'sd8500;
    localparam longint P_LOW     = 64'sd1000;
    localparam longint P_HIGH    = 64'sd120000;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_centi;
        logic        [PRES_W-1:0] pressure_centi;
    } reading_t;

    cfg_t     cal;
    reading_t compensated_q[$];

    // Second-order compensation with 64-bit intermediates. Every shift is an
    // arithmetic shift of a signed value, so it rounds toward minus infinity.
    function automatic reading_t compensate(input logic [RAW_W-1:0] raw_p,
                                            input logic [RAW_W-1:0] raw_t,
                                            input cfg_t c);
        longint   d1, dt, temp, off, sens, t2, off2, sens2, sq, p;
        reading_t r;
        d1   = longint'(raw_p);
        dt   = longint'(raw_t) - longint'(c.ref_temperature) * 64'sd256;
        temp = T_REF + ((dt * longint'(c.temp_sens_coeff)) >>> 23);
        off  = longint'(c.offset_coeff) * 64'sd65536
             + ((longint'(c.offset_temp_coeff) * dt) >>> 7);
        sens = longint'(c.sens_coeff) * 64'sd32768
             + ((longint'(c.sens_temp_coeff) * dt) >>> 8);
        t2    = 64'sd0;
        off2  = 64'sd0;
        sens2 = 64'sd0;
        if (temp < T_REF)
        begin
            sq    = (temp - T_REF) * (temp - T_REF);
            t2    = (dt * dt) >>> 31;
            off2  = (64'sd5 * sq) >>> 1;
            sens2 = off2 >>> 1;
            // The very cold term is keyed on the first-order temperature.
            if (temp < T_COLD)
            begin
                sq    = (temp - T_COLD) * (temp - T_COLD);
                off2  = off2 + 64'sd7 * sq;
                sens2 = sens2 + ((64'sd11 * sq) >>> 1);
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p    = (((d1 * sens) >>> 21) - off) >>> 15;
        if (temp < T_LOW)
            temp = T_LOW;
        else if (temp > T_HIGH)
            temp = T_HIGH;
        if (p < P_LOW)
            p = P_LOW;
        else if (p > P_HIGH)
            p = P_HIGH;
        r.temperature_centi = temp[TEMP_W-1:0];
        r.pressure_centi    = p[PRES_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t           want;
        logic [COEFF_W-1:0] word;
        if (!rst_n)
        begin
            cal = '0;
            compensated_q.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_SENS:        cal.sens_coeff        = pwdata[COEFF_W-1:0];
                    REG_OFFSET:      cal.offset_coeff      = pwdata[COEFF_W-1:0];
                    REG_SENS_TEMP:   cal.sens_temp_coeff   = pwdata[COEFF_W-1:0];
                    REG_OFFSET_TEMP: cal.offset_temp_coeff = pwdata[COEFF_W-1:0];
                    REG_REF_TEMP:    cal.ref_temperature   = pwdata[COEFF_W-1:0];
                    REG_TEMP_SENS:   cal.temp_sens_coeff   = pwdata[COEFF_W-1:0];
                    default: ;
                endcase
            end

            if (psel && penable && !pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_SENS:        word = cal.sens_coeff;
                    REG_OFFSET:      word = cal.offset_coeff;
                    REG_SENS_TEMP:   word = cal.sens_temp_coeff;
                    REG_OFFSET_TEMP: word = cal.offset_temp_coeff;
                    REG_REF_TEMP:    word = cal.ref_temperature;
                    REG_TEMP_SENS:   word = cal.temp_sens_coeff;
                    default:         word = '0;
                endcase
                if (paddr[ADDR_W-1:2] <= REG_TEMP_SENS && prdata !== DATA_W'(word))
                begin
                    $error("prdata mismatch at 0x%0h: expected 0x%0h, actual 0x%0h",
                           paddr, DATA_W'(word), prdata);
                    mismatches++;
                end
            end

            if (result.valid && result.ready)
            begin
                if (compensated_q.size() == 0)
                begin
                    $error("result transfer with no reading outstanding: %0d / %0d",
                           result.temperature_centi, result.pressure_centi);
                    mismatches++;
                end
                else
                begin
                    want = compensated_q.pop_front();
                    if (result.temperature_centi !== want.temperature_centi)
                    begin
                        $error("temperature_centi mismatch: expected %0d, actual %0d",
                               want.temperature_centi, result.temperature_centi);
                        mismatches++;
                    end
                    if (result.pressure_centi !== want.pressure_centi)
                    begin
                        $error("pressure_centi mismatch: expected %0d, actual %0d",
                               want.pressure_centi, result.pressure_centi);
                        mismatches++;
                    end
                end
            end

            if (sample.valid && sample.ready)
                compensated_q.push_back(compensate(sample.raw_pressure,
                                                   sample.raw_temperature, cal));
            pending = compensated_q.size();
        end
    end

endmodule

// ===== dv/tb_baro_pressure_temp_compensation.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_baro_pressure_temp_compensation
// Drives calibration words over the register port and raw reading pairs into
// the compensation block, with random idling on both channels, a long result
// stall and a full drain. A checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_baro_pressure_temp_compensation;
    import bpc_pkg::*;

    localparam int RAW_MAX            = (1 << RAW_W) - 1;
    localparam int RANDOM_PHASES      = 6;
    localparam int READINGS_PER_PHASE = 230;
    localparam int HOLD_CYCLES        = 300;
    localparam int QUIET_LIMIT        = 5000;

    // Bit n set: that random phase idles the given side.
    localparam logic [RANDOM_PHASES-1:0] SRC_IDLE_PHASES  = 6'b110101;
    localparam logic [RANDOM_PHASES-1:0] SINK_IDLE_PHASES = 6'b111001;

    localparam logic [2:0] IDX_SPARE_LO = 3'd6;
    localparam logic [2:0] IDX_SPARE_HI = 3'd7;

    // First-order temperature step from 20.00 C down to -15.00 C.
    localparam longint COLD_STEP = -64'sd3500;

    localparam cfg_t TYPICAL_CAL = '{
        sens_coeff:        16'd40127,
        offset_coeff:      16'd36924,
        sens_temp_coeff:   16'd23317,
        offset_temp_coeff: 16'd23282,
        ref_temperature:   16'd33464,
        temp_sens_coeff:   16'd28312
    };
    localparam logic [RAW_W-1:0] TYPICAL_D1 = 24'd9085466;
    localparam logic [RAW_W-1:0] TYPICAL_D2 = 24'd8569150;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    int                mismatches;
    int                pending;
    int                quiet_cycles;
    logic              src_idles;
    logic              sink_idles;
    logic              hold_request;
    cfg_t              cal_now;

    bpc_in_if  sample_ch();
    bpc_out_if result_ch();

    baro_pressure_temp_compensation dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .sample  (sample_ch),
        .result  (result_ch)
    );

    bpc_comp_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .sample     (sample_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(8, 40));
        return int'($urandom_range(1, 3));
    endfunction

    function automatic logic [RAW_W-1:0] clip_raw(input longint v);
        if (v < 0)
            return '0;
        if (v > RAW_MAX)
            return RAW_W'(RAW_MAX);
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [RAW_W-1:0] raw_corner();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return RAW_W'(RAW_MAX);
            default: return RAW_W'($urandom_range(0, RAW_MAX));
        endcase
    endfunction

    function automatic logic [COEFF_W-1:0] cal_word();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return COEFF_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic cfg_t random_cal();
        cfg_t c;
        c.sens_coeff        = cal_word();
        c.offset_coeff      = cal_word();
        c.sens_temp_coeff   = cal_word();
        c.offset_temp_coeff = cal_word();
        c.ref_temperature   = cal_word();
        c.temp_sens_coeff   = cal_word();
        return c;
    endfunction

    // Half of the raw temperatures land near the reference point so that the warm,
    // cold and very cold branches all see plenty of traffic.
    function automatic logic [2*RAW_W-1:0] random_pair(input cfg_t c);
        logic [RAW_W-1:0] p;
        logic [RAW_W-1:0] t;
        longint           near_t;
        p = RAW_W'($urandom_range(0, RAW_MAX));
        case ($urandom_range(0, 3))
            0:
            begin
                t = RAW_W'($urandom_range(0, RAW_MAX));
            end
            1:
            begin
                p = raw_corner();
                t = raw_corner();
            end
            default:
            begin
                near_t = longint'(c.ref_temperature) * 64'sd256
                       + longint'($urandom_range(0, 1 << 22)) - 64'sd2097152;
                t = clip_raw(near_t);
            end
        endcase
        return {p, t};
    endfunction

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
    endtask

    task automatic apb_park();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // The upper pwdata bits carry junk; only the low word may stick.
    task automatic set_calibration(input cfg_t c, input logic [15:0] junk);
        for (int i = 0; i <= int'(REG_TEMP_SENS); i++)
            apb_access(1'b1, {reg_idx_t'(i), 2'b00},
                       {junk, c[(int'(REG_TEMP_SENS) - i) * COEFF_W +: COEFF_W]});
        cal_now = c;
        apb_park();
    endtask

    task automatic read_calibration();
        for (int i = 0; i <= int'(REG_TEMP_SENS); i++)
            apb_access(1'b0, {reg_idx_t'(i), 2'b00}, '0);
        apb_park();
    endtask

    task automatic send_reading(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
        sample_ch.valid           <= 1'b1;
        sample_ch.raw_pressure    <= p;
        sample_ch.raw_temperature <= t;
        do @(posedge clk); while (!sample_ch.ready);
        @(negedge clk);
    endtask

    task automatic idle_gap(input int n);
        sample_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_results_done();
        sample_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    // Result side: random stalls, plus one long hold on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else if (sink_idles && $urandom_range(0, 4) == 0)
            begin
                stall_left = gap_len() - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    initial quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        cfg_t                 cal;
        logic [2*RAW_W-1:0]   pair;
        longint               dt0;
        longint               ref_raw;

        rst_n                     = 1'b0;
        psel                      = 1'b0;
        penable                   = 1'b0;
        pwrite                    = 1'b0;
        paddr                     = '0;
        pwdata                    = '0;
        sample_ch.valid           = 1'b0;
        sample_ch.raw_pressure    = '0;
        sample_ch.raw_temperature = '0;
        result_ch.ready           = 1'b0;
        src_idles                 = 1'b0;
        sink_idles                = 1'b1;
        hold_request              = 1'b0;
        cal_now                   = '0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Unwritten calibration: every word reads zero and is used as zero.
        read_calibration();
        send_reading('0, '0);
        send_reading(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
        send_reading(24'h555555, 24'hAAAAAA);

        wait_results_done();
        set_calibration(TYPICAL_CAL, 16'h5A5A);
        // Writes past the last register must leave every word alone.
        apb_access(1'b1, {IDX_SPARE_LO, 2'b00}, '1);
        apb_access(1'b1, {IDX_SPARE_HI, 2'b00}, '1);
        apb_park();
        read_calibration();

        send_reading('0, '0);
        send_reading(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
        send_reading('0, RAW_W'(RAW_MAX));
        send_reading(RAW_W'(RAW_MAX), '0);
        send_reading(TYPICAL_D1, TYPICAL_D2);
        ref_raw = longint'(TYPICAL_CAL.ref_temperature) * 64'sd256;
        // Raw temperatures one below, at and one above the reference, around 20.00 C.
        for (int j = -1; j <= 1; j++)
            send_reading(TYPICAL_D1, clip_raw(ref_raw + j));
        // Around the -15.00 C boundary; the middle one lands exactly on it.
        dt0 = (COLD_STEP * (64'sd1 <<< 23)) / longint'(TYPICAL_CAL.temp_sens_coeff);
        for (int j = -2; j <= 2; j++)
            send_reading(TYPICAL_D1, clip_raw(ref_raw + dt0 + 150 * j));

        wait_results_done();
        set_calibration('1, 16'hFFFF);
        read_calibration();
        send_reading('0, '0);
        send_reading(RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
        send_reading('0, RAW_W'(RAW_MAX));
        send_reading(RAW_W'(RAW_MAX), '0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_results_done();
            if (ph == 0)
                cal = TYPICAL_CAL;
            else
                cal = random_cal();
            if (ph == 2)
            begin
                // Reference at the top of the range pushes most readings cold.
                cal.ref_temperature = '1;
                cal.temp_sens_coeff = '1;
            end
            set_calibration(cal, 16'($urandom_range(0, 16'hFFFF)));
            read_calibration();
            src_idles  = SRC_IDLE_PHASES[ph];
            sink_idles = SINK_IDLE_PHASES[ph];
            for (int n = 0; n < READINGS_PER_PHASE; n++)
            begin
                // Long result stall while samples keep coming, so the
                // pipeline fills and the sample channel backs up.
                if (ph == 1 && n == 40)
                    hold_request = 1'b1;
                if (ph == 3 && n == READINGS_PER_PHASE / 2)
                    wait_results_done();
                pair = random_pair(cal_now);
                send_reading(pair[2*RAW_W-1:RAW_W], pair[RAW_W-1:0]);
                if (src_idles && $urandom_range(0, 3) == 0)
                    idle_gap(gap_len());
            end
        end

        wait_results_done();
        repeat (2 * NSTG) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/bpc_pkg.sv
sv/bpc_in_if.sv
sv/bpc_out_if.sv
sv/bpc_core.sv
sv/baro_pressure_temp_compensation.sv
dv/bpc_comp_checker.sv
dv/tb_baro_pressure_temp_compensation.sv
